@@ sv/hse_pkg.sv @@
// Package for the heap sort engine: value and slot types, the per-cell
// command word and the control state encoding. No dependencies.
`default_nettype none

package hse_pkg;

  localparam int VALUE_W          = 32;
  localparam int DEFAULT_CAPACITY = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  // One storage slot of the sorting row
  typedef struct packed {
    logic   valid;
    value_t value;
  } slot_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic   load;   // insert din at its ordered place
    logic   drain;  // shift the row one slot toward cell 0
    value_t din;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

endpackage

`default_nettype wire

@@ sv/hse_cell.sv @@
// One cell of the ordered insertion row: holds one slot, compares it with
// the broadcast value and trades slots with its neighbors. Uses hse_pkg.
`default_nettype none

module hse_cell (
  input  wire              clk,
  input  wire              rst,
  input  hse_pkg::cell_ctrl_t ctrl,
  input  hse_pkg::slot_t   left,         // slot of the cell nearer to the head
  input  wire              left_behind,  // left cell yields to the new word
  input  hse_pkg::slot_t   right,        // slot of the cell farther from the head
  output hse_pkg::slot_t   slot,
  output logic             behind        // this cell yields to the new word
);

  hse_pkg::slot_t slot_next;

  // Yield when empty or when the held value is strictly larger
  assign behind = !slot.valid || (slot.value > ctrl.din);

  // Insert, shift right behind the insertion point, or shift toward the head
  always_comb begin
    slot_next = slot;
    if (ctrl.load) begin
      if (behind) begin
        if (left_behind) begin
          slot_next = left;
        end else begin
          slot_next.valid = 1'b1;
          slot_next.value = ctrl.din;
        end
      end
    end else if (ctrl.drain) begin
      slot_next = right;
    end
  end

  always_ff @(posedge clk) begin
    slot.value <= slot_next.value;
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
  end

endmodule

`default_nettype wire

@@ sv/heap_sort_engine_top.sv @@
// Top level of the heap sort engine: a row of hse_cell instances kept in
// ascending order, plus load/drain control. Uses hse_pkg and hse_cell.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_stall, value, is_last       | into block
//   output  | out_valid, out_stall, value_res,         | out of block
//           | is_last_res, overflowed                  |
//
// Flow: one input word per cycle while loading; every word that finds room
// lands at its ordered place in the cell row in the cycle it is accepted, so
// the set is sorted when the last word is in. A set of n words then drains
// at one word per cycle from cell 0 while out_stall is low.
// Reset clears the cell valid bits, the fill count and the overflow flag.
// in_stall is high while a set drains; out_stall holds the row in place.
`default_nettype none

module heap_sort_engine_top #(
  parameter int CAPACITY = hse_pkg::DEFAULT_CAPACITY
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire signed [31:0]    value,
  input  wire                  is_last,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic signed [31:0]   value_res,
  output logic                 is_last_res,
  output logic                 overflowed
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  hse_pkg::state_t     state;
  hse_pkg::state_t     state_next;
  hse_pkg::cell_ctrl_t ctrl;
  logic [CNT_W-1:0]    count;
  logic                ovf;
  logic                in_acc;
  logic                out_acc;
  logic                has_room;

  hse_pkg::slot_t      cell_q [CAPACITY];
  logic                behind [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign has_room = (count < CNT_W'(CAPACITY));

  // Next state: drain after the last word, load again after the last result
  always_comb begin
    state_next = state;
    unique case (state)
      hse_pkg::ST_LOAD: begin
        if (in_acc && is_last) state_next = hse_pkg::ST_DRAIN;
      end
      hse_pkg::ST_DRAIN: begin
        if (out_acc && is_last_res) state_next = hse_pkg::ST_LOAD;
      end
      default: state_next = hse_pkg::ST_LOAD;
    endcase
  end

  // Outputs: handshakes and the row command
  always_comb begin
    in_stall   = 1'b0;
    out_valid  = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.drain = 1'b0;
    ctrl.din   = value;
    unique case (state)
      hse_pkg::ST_LOAD: begin
        ctrl.load = in_valid && has_room;
      end
      hse_pkg::ST_DRAIN: begin
        in_stall   = 1'b1;
        out_valid  = cell_q[0].valid;
        ctrl.drain = cell_q[0].valid && !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hse_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Track fill count and dropped words; clear both at the end of a run
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (out_acc && is_last_res) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (in_acc) begin
      if (has_room) begin
        count <= count + CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Row of cells, cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hse_pkg::slot_t left_slot;
    hse_pkg::slot_t right_slot;
    logic           left_behind;

    if (i == 0) begin : g_head
      assign left_slot   = '0;
      assign left_behind = 1'b0;
    end else begin : g_body
      assign left_slot   = cell_q[i-1];
      assign left_behind = behind[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = cell_q[i+1];
    end

    hse_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left        (left_slot),
      .left_behind (left_behind),
      .right       (right_slot),
      .slot        (cell_q[i]),
      .behind      (behind[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  // Present the head of the row
  assign value_res   = cell_q[0].value;
  assign is_last_res = !cell_q[1].valid;
  assign overflowed  = ovf;

`ifndef SYNTH
  logic [CAPACITY-1:0] order_ok;

  for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order
    assign order_ok[j] = !cell_q[j+1].valid || (cell_q[j].value <= cell_q[j+1].value);
  end
  assign order_ok[CAPACITY-1] = 1'b1;

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state == hse_pkg::ST_LOAD) |-> ($countones(valid_vec) == int'(count)))
    else $error("fill count disagrees with occupied cells");

  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("occupied cells are not a prefix of the row");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("cell row out of ascending order");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_acc && is_last_res) |=> (!out_valid && valid_vec == '0))
    else $error("cells left over after the last result");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> ($past(count) == CNT_W'(CAPACITY)))
    else $error("overflow raised with room left");
`endif

endmodule

`default_nettype wire
